[hw/rtl/tau_pkg.sv]
`default_nettype none

package tau_pkg;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_CMP = 2'd3
  } tau_mode_t;

  localparam logic [1:0] ORDER_SAME    = 2'b00;
  localparam logic [1:0] ORDER_LATER   = 2'b01;
  localparam logic [1:0] ORDER_EARLIER = 2'b11;

  localparam int unsigned TAU_STAGES = 8;

  localparam logic [29:0] USEC_PER_SEC = 30'd1000000;
  localparam logic [29:0] NSEC_PER_SEC = 30'd1000000000;

  // Quotient estimate q ~ ((t >> SHIFT) * RECIP) >> RSHIFT, with RECIP = 2^(SHIFT+RSHIFT)/U.
  // The estimate is never high and at most one low.
  localparam int unsigned US_SHIFT  = 19;
  localparam int unsigned US_RSHIFT = 18;
  localparam logic [17:0] US_RECIP  = 18'd137438;
  localparam int unsigned NS_SHIFT  = 29;
  localparam int unsigned NS_RSHIFT = 18;
  localparam logic [17:0] NS_RECIP  = 18'd140737;

  typedef struct packed {
    tau_mode_t   mode;
    logic        nano;
    logic [31:0] alt_sec;
    logic [30:0] alt_frac;
    logic [1:0]  order;
  } tau_side_t;

  typedef struct packed {
    tau_mode_t   mode;
    logic        nano;
    logic [31:0] a_sec;
    logic [29:0] a_frac;
    logic [31:0] b_sec;
    logic [29:0] b_frac;
    logic [31:0] fac;
    logic        neg;
    logic [31:0] mag;
  } tau_s1_t;

  typedef struct packed {
    tau_side_t   side;
    logic        neg;
    logic [63:0] p;
    logic [61:0] fp;
  } tau_s2_t;

  typedef struct packed {
    tau_side_t   side;
    logic        neg;
    logic [31:0] sec;
    logic [45:0] fpart;
    logic [29:0] left;
  } tau_s3_t;

  typedef struct packed {
    tau_side_t   side;
    logic [31:0] sec;
    logic [47:0] total;
  } tau_s4_t;

  function automatic logic [29:0] units(input logic nano);
    return nano ? NSEC_PER_SEC : USEC_PER_SEC;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tau_front.sv]
`default_nettype none

module tau_front (
  input  wire logic              clk,
  input  wire logic [1:0]        load,
  input  wire logic              nano,
  input  wire logic [1:0]        mode,
  input  wire logic [31:0]       a_sec,
  input  wire logic [29:0]       a_frac,
  input  wire logic [31:0]       b_sec,
  input  wire logic [29:0]       b_frac,
  input  wire logic [31:0]       fac,
  output tau_pkg::tau_s2_t       s2_o
);
  import tau_pkg::*;

  tau_s1_t s1_r, s1_nxt;
  tau_s2_t s2_r, s2_nxt;

  logic [29:0] u_in;
  logic [30:0] u31;
  logic [30:0] fsum;

  // Stage 1: saturate the fractions and take the magnitude of the seconds.
  always_comb begin
    u_in           = units(nano);
    s1_nxt.mode    = tau_mode_t'(mode);
    s1_nxt.nano    = nano;
    s1_nxt.a_sec   = a_sec;
    s1_nxt.b_sec   = b_sec;
    s1_nxt.a_frac  = (a_frac >= u_in) ? (u_in - 30'd1) : a_frac;
    s1_nxt.b_frac  = (b_frac >= u_in) ? (u_in - 30'd1) : b_frac;
    s1_nxt.fac     = fac;
    s1_nxt.neg     = a_sec[31];
    s1_nxt.mag     = a_sec[31] ? (~a_sec + 32'd1) : a_sec;
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage 2: both products of the scale path, plus the add, subtract and compare results.
  always_comb begin
    u31  = {1'b0, units(s1_r.nano)};
    fsum = {1'b0, s1_r.a_frac} + {1'b0, s1_r.b_frac};

    s2_nxt.neg  = s1_r.neg;
    s2_nxt.p    = 64'(s1_r.fac) * 64'(s1_r.mag);
    s2_nxt.fp   = 62'(s1_r.fac) * 62'(s1_r.a_frac);

    s2_nxt.side.mode     = s1_r.mode;
    s2_nxt.side.nano     = s1_r.nano;
    s2_nxt.side.alt_sec  = 32'd0;
    s2_nxt.side.alt_frac = 31'd0;
    s2_nxt.side.order    = ORDER_SAME;

    case (s1_r.mode)
      MODE_ADD: begin
        if (fsum >= u31) begin
          s2_nxt.side.alt_frac = fsum - u31;
          s2_nxt.side.alt_sec  = s1_r.a_sec + s1_r.b_sec + 32'd1;
        end else begin
          s2_nxt.side.alt_frac = fsum;
          s2_nxt.side.alt_sec  = s1_r.a_sec + s1_r.b_sec;
        end
      end
      MODE_SUB: begin
        if (s1_r.b_frac > s1_r.a_frac) begin
          s2_nxt.side.alt_frac = {1'b0, s1_r.a_frac} + u31 - {1'b0, s1_r.b_frac};
          s2_nxt.side.alt_sec  = s1_r.a_sec - s1_r.b_sec - 32'd1;
        end else begin
          s2_nxt.side.alt_frac = {1'b0, s1_r.a_frac} - {1'b0, s1_r.b_frac};
          s2_nxt.side.alt_sec  = s1_r.a_sec - s1_r.b_sec;
        end
      end
      MODE_CMP: begin
        if ($signed(s1_r.a_sec) > $signed(s1_r.b_sec)) begin
          s2_nxt.side.order = ORDER_LATER;
        end else if ($signed(s1_r.a_sec) < $signed(s1_r.b_sec)) begin
          s2_nxt.side.order = ORDER_EARLIER;
        end else if (s1_r.a_frac > s1_r.b_frac) begin
          s2_nxt.side.order = ORDER_LATER;
        end else if (s1_r.a_frac < s1_r.b_frac) begin
          s2_nxt.side.order = ORDER_EARLIER;
        end else begin
          s2_nxt.side.order = ORDER_SAME;
        end
      end
      default: begin
        s2_nxt.side.order = ORDER_SAME;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_o = s2_r;

endmodule

`default_nettype wire

[hw/rtl/tau_scale.sv]
`default_nettype none

module tau_scale (
  input  wire logic              clk,
  input  wire logic [1:0]        load,
  input  wire tau_pkg::tau_s2_t  s2_i,
  output tau_pkg::tau_s4_t       s4_o
);
  import tau_pkg::*;

  tau_s3_t s3_r, s3_nxt;
  tau_s4_t s4_r, s4_nxt;

  logic [45:0] left_prod;
  logic [31:0] whole;

  // Stage 3: the 2^-16 leftover of the seconds product is scaled to fraction units.
  always_comb begin
    left_prod    = 46'(units(s2_i.side.nano)) * 46'(s2_i.p[15:0]);
    whole        = s2_i.p[47:16];
    s3_nxt.side  = s2_i.side;
    s3_nxt.neg   = s2_i.neg;
    s3_nxt.sec   = s2_i.neg ? (~whole + 32'd1) : whole;
    s3_nxt.fpart = s2_i.fp[61:16];
    s3_nxt.left  = left_prod[45:16];
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 4: the leftover carries the sign of the seconds product.
  always_comb begin
    s4_nxt.side  = s3_r.side;
    s4_nxt.sec   = s3_r.sec;
    s4_nxt.total = s3_r.neg ? ({2'b00, s3_r.fpart} - {18'd0, s3_r.left})
                            : ({2'b00, s3_r.fpart} + {18'd0, s3_r.left});
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s4_r <= s4_nxt;
    end
  end

  assign s4_o = s4_r;

endmodule

`default_nettype wire

[hw/rtl/tau_norm.sv]
`default_nettype none

module tau_norm (
  input  wire logic              clk,
  input  wire logic [3:0]        load,
  input  wire tau_pkg::tau_s4_t  s4_i,
  output logic [31:0]            result_seconds,
  output logic [30:0]            result_fraction,
  output logic [1:0]             order
);
  import tau_pkg::*;

  tau_side_t   side5_r, side6_r, side7_r;
  logic [31:0] sec5_r, sec6_r, sec7_r;
  logic [47:0] total5_r;
  logic [30:0] tlow6_r;
  logic        tneg6_r, tneg7_r;
  logic [17:0] qest5_r, qest5_nxt, qest6_r, qest7_r;
  logic [30:0] qu6_r, qu6_nxt;
  logic [30:0] rem7_r, rem7_nxt;
  logic [31:0] sec_out_r, sec_out_nxt;
  logic [30:0] frac_out_r, frac_out_nxt;
  logic [1:0]  order_out_r, order_out_nxt;

  logic [17:0] y;
  logic [35:0] est_prod;
  logic [47:0] qu_full;
  logic [30:0] u31;
  logic [30:0] frac_m;
  logic [17:0] q_fin;

  // Stage 5: reciprocal estimate of total / U from the top bits of total.
  always_comb begin
    if (s4_i.side.nano) begin
      y         = s4_i.total[NS_SHIFT +: 18];
      est_prod  = 36'(y) * 36'(NS_RECIP);
      qest5_nxt = est_prod[NS_RSHIFT +: 18];
    end else begin
      y         = s4_i.total[US_SHIFT +: 18];
      est_prod  = 36'(y) * 36'(US_RECIP);
      qest5_nxt = est_prod[US_RSHIFT +: 18];
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      side5_r  <= s4_i.side;
      sec5_r   <= s4_i.sec;
      total5_r <= s4_i.total;
      qest5_r  <= qest5_nxt;
    end
  end

  // Stage 6: back-multiply; the remainder is below 2U, so 31 bits suffice.
  always_comb begin
    qu_full = 48'(qest5_r) * 48'(units(side5_r.nano));
    qu6_nxt = qu_full[30:0];
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      side6_r <= side5_r;
      sec6_r  <= sec5_r;
      tlow6_r <= total5_r[30:0];
      tneg6_r <= total5_r[47];
      qest6_r <= qest5_r;
      qu6_r   <= qu6_nxt;
    end
  end

  // Stage 7: a negative fraction passes through untouched.
  assign rem7_nxt = tneg6_r ? tlow6_r : (tlow6_r - qu6_r);

  always_ff @(posedge clk) begin
    if (load[2]) begin
      side7_r <= side6_r;
      sec7_r  <= sec6_r;
      tneg7_r <= tneg6_r;
      qest7_r <= qest6_r;
      rem7_r  <= rem7_nxt;
    end
  end

  // Stage 8: one correction step, then pick the result for the operation.
  always_comb begin
    u31 = {1'b0, units(side7_r.nano)};
    if (tneg7_r) begin
      frac_m = rem7_r;
      q_fin  = 18'd0;
    end else if (rem7_r >= u31) begin
      frac_m = rem7_r - u31;
      q_fin  = qest7_r + 18'd1;
    end else begin
      frac_m = rem7_r;
      q_fin  = qest7_r;
    end

    case (side7_r.mode)
      MODE_MUL: begin
        sec_out_nxt   = sec7_r + 32'(q_fin);
        frac_out_nxt  = frac_m;
        order_out_nxt = ORDER_SAME;
      end
      default: begin
        sec_out_nxt   = side7_r.alt_sec;
        frac_out_nxt  = side7_r.alt_frac;
        order_out_nxt = side7_r.order;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      sec_out_r   <= sec_out_nxt;
      frac_out_r  <= frac_out_nxt;
      order_out_r <= order_out_nxt;
    end
  end

  assign result_seconds  = sec_out_r;
  assign result_fraction = frac_out_r;
  assign order           = order_out_r;

endmodule

`default_nettype wire

[hw/rtl/timestamp_arithmetic_unit_core.sv]
// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_stall    mode, a/b seconds and fraction, factor
// out_      result     out_valid / out_stall  result_seconds, result_fraction, order
// cfg_      write      cfg_we                 nano_resolution in cfg_wdata
//
// One request is taken per cycle while in_stall is low; its result leaves from the last stage register.
// The 32x32 seconds product and the 32x30 fraction product in stage 2 set the clock period.
// Reset clears the valid bits of every stage and sets microsecond resolution.
// Each stage holds while the stage after it is full and cannot move, so a stalled
// output still lets earlier stages close up bubbles and take new requests.
`default_nettype none

module timestamp_arithmetic_unit_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [31:0] in_a_seconds,
  input  wire logic [29:0]        in_a_fraction,
  input  wire logic signed [31:0] in_b_seconds,
  input  wire logic [29:0]        in_b_fraction,
  input  wire logic [31:0]        in_factor,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_seconds,
  output logic signed [30:0]      out_result_fraction,
  output logic signed [1:0]       out_order
);
  import tau_pkg::*;

  logic                  nano_r;
  logic [TAU_STAGES-1:0] vld_r, vld_nxt;
  logic [TAU_STAGES-1:0] load;
  tau_s2_t               s2;
  tau_s4_t               s4;
  logic [31:0]           res_sec;
  logic [30:0]           res_frac;
  logic [1:0]            res_order;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nano_r <= 1'b0;
    end else if (cfg_we) begin
      nano_r <= cfg_wdata;
    end
  end

  // A stage loads when it is empty or when its content moves on.
  always_comb begin
    load[TAU_STAGES-1] = !vld_r[TAU_STAGES-1] || !out_stall;
    for (int i = TAU_STAGES - 2; i >= 0; i--) begin
      load[i] = !vld_r[i] || load[i+1];
    end
    vld_nxt[0] = load[0] ? in_valid : vld_r[0];
    for (int i = 1; i < TAU_STAGES; i++) begin
      vld_nxt[i] = load[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !load[0];
  assign out_valid = vld_r[TAU_STAGES-1];

  tau_front u_front (
    .clk    (clk),
    .load   (load[1:0]),
    .nano   (nano_r),
    .mode   (in_mode),
    .a_sec  (in_a_seconds),
    .a_frac (in_a_fraction),
    .b_sec  (in_b_seconds),
    .b_frac (in_b_fraction),
    .fac    (in_factor),
    .s2_o   (s2)
  );

  tau_scale u_scale (
    .clk  (clk),
    .load (load[3:2]),
    .s2_i (s2),
    .s4_o (s4)
  );

  tau_norm u_norm (
    .clk             (clk),
    .load            (load[7:4]),
    .s4_i            (s4),
    .result_seconds  (res_sec),
    .result_fraction (res_frac),
    .order           (res_order)
  );

  assign out_result_seconds  = res_sec;
  assign out_result_fraction = res_frac;
  assign out_order           = res_order;

endmodule

`default_nettype wire

[hw/rtl/tau_checker.sv]
`default_nettype none

module tau_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_result_seconds,
  input wire logic signed [30:0] out_result_fraction,
  input wire logic signed [1:0]  out_order
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_seconds)
      && $stable(out_result_fraction) && $stable(out_order))
    else $error("stalled result changed");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_order != 2'sb10)
    else $error("order outside -1..1");

  // Only a compare yields a nonzero order, and a compare leaves the time fields clear.
  a_cmp_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_order != 2'sb00 |->
      out_result_seconds == 32'sd0 && out_result_fraction == 31'sd0)
    else $error("compare result carries a timestamp");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_fraction < 31'sd1000000000
      && out_result_fraction > -31'sd1000000000)
    else $error("result fraction beyond one second");

endmodule

bind timestamp_arithmetic_unit_core tau_checker u_tau_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_result_seconds  (out_result_seconds),
  .out_result_fraction (out_result_fraction),
  .out_order           (out_order)
);

`default_nettype wire

[sim/timestamp_checker.sv]
`default_nettype none

module timestamp_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_a_seconds,
  input  wire logic [29:0] in_a_fraction,
  input  wire logic [31:0] in_b_seconds,
  input  wire logic [29:0] in_b_fraction,
  input  wire logic [31:0] in_factor,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] out_result_seconds,
  input  wire logic [30:0] out_result_fraction,
  input  wire logic [1:0]  out_order,
  output int               errors,
  output int               pending
);
  import tau_pkg::*;

  typedef struct packed {
    logic [31:0] sec;
    logic [30:0] frac;
    logic [1:0]  order;
  } stamp_t;

  stamp_t expected_stamps[$];
  logic   nano;

  function automatic stamp_t predict_stamp(input tau_mode_t mode, input logic [31:0] a_sec,
                                           input logic [29:0] a_frac, input logic [31:0] b_sec,
                                           input logic [29:0] b_frac, input logic [31:0] fac,
                                           input logic use_ns);
    logic [63:0]        u;
    logic [63:0]        af;
    logic [63:0]        bf;
    logic [63:0]        f;
    logic [63:0]        mag;
    logic [63:0]        p;
    logic [63:0]        q;
    logic [63:0]        left;
    logic [63:0]        fpart;
    logic signed [63:0] total;
    logic               neg;
    stamp_t             r;
    u = use_ns ? {34'd0, NSEC_PER_SEC} : {34'd0, USEC_PER_SEC};
    // Fractions at or above one second saturate just below it.
    af = ({34'd0, a_frac} >= u) ? u - 64'd1 : {34'd0, a_frac};
    bf = ({34'd0, b_frac} >= u) ? u - 64'd1 : {34'd0, b_frac};
    r = '0;
    case (mode)
      MODE_ADD: begin
        f = af + bf;
        r.sec = a_sec + b_sec;
        if (f >= u) begin
          f = f - u;
          r.sec = r.sec + 32'd1;
        end
        r.frac = f[30:0];
      end
      MODE_SUB: begin
        if (bf > af) begin
          f = af + u - bf;
          r.sec = a_sec - b_sec - 32'd1;
        end else begin
          f = af - bf;
          r.sec = a_sec - b_sec;
        end
        r.frac = f[30:0];
      end
      MODE_MUL: begin
        neg = a_sec[31];
        mag = neg ? {32'd0, ~a_sec + 32'd1} : {32'd0, a_sec};
        if (neg && a_sec == 32'h8000_0000) begin
          mag = 64'h8000_0000;
        end
        p = {32'd0, fac} * mag;
        q = p >> 16;
        // The sub-second part of the seconds product, scaled to units.
        left = (u * {48'd0, p[15:0]}) >> 16;
        fpart = ({32'd0, fac} * af) >> 16;
        r.sec = neg ? (32'd0 - q[31:0]) : q[31:0];
        total = neg ? $signed(fpart) - $signed(left) : $signed(fpart + left);
        if (total >= $signed(u)) begin
          f = total;
          q = f / u;
          r.sec = r.sec + q[31:0];
          f = f % u;
          total = f;
        end
        r.frac = total[30:0];
      end
      default: begin
        if ($signed(a_sec) > $signed(b_sec)) begin
          r.order = ORDER_LATER;
        end else if ($signed(a_sec) < $signed(b_sec)) begin
          r.order = ORDER_EARLIER;
        end else if (af > bf) begin
          r.order = ORDER_LATER;
        end else if (af < bf) begin
          r.order = ORDER_EARLIER;
        end else begin
          r.order = ORDER_SAME;
        end
      end
    endcase
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    nano = 1'b0;
  end

  always @(posedge clk) begin
    stamp_t want;
    stamp_t got;
    if (!rst_n) begin
      nano = 1'b0;
      expected_stamps.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_stamps.push_back(predict_stamp(tau_mode_t'(in_mode), in_a_seconds,
                                                in_a_fraction, in_b_seconds, in_b_fraction,
                                                in_factor, nano));
      end
      if (out_valid && !out_stall) begin
        got = {out_result_seconds, out_result_fraction, out_order};
        if (expected_stamps.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: sec %0d frac %0d order %0d",
                     $signed(got.sec), $signed(got.frac), $signed(got.order));
          end
        end else begin
          want = expected_stamps.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("result mismatch: expected sec %0d frac %0d order %0d, got sec %0d frac %0d order %0d",
                       $signed(want.sec), $signed(want.frac), $signed(want.order),
                       $signed(got.sec), $signed(got.frac), $signed(got.order));
            end
          end
        end
      end
      // The register only changes while nothing is in flight.
      if (cfg_we) begin
        nano = cfg_wdata;
      end
    end
    pending <= expected_stamps.size();
  end

endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top;
  import tau_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode = 2'd0;
  logic signed [31:0] in_a_seconds = '0;
  logic [29:0]        in_a_fraction = '0;
  logic signed [31:0] in_b_seconds = '0;
  logic [29:0]        in_b_fraction = '0;
  logic [31:0]        in_factor = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_result_seconds;
  logic signed [30:0] out_result_fraction;
  logic signed [1:0]  out_order;

  int tx_idle_pct = 23;
  int rx_idle_pct = 80;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit hold_wanted = 1'b0;
  int quiet = 0;
  int errors;
  int pending;

  timestamp_arithmetic_unit_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_a_seconds        (in_a_seconds),
    .in_a_fraction       (in_a_fraction),
    .in_b_seconds        (in_b_seconds),
    .in_b_fraction       (in_b_fraction),
    .in_factor           (in_factor),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_seconds  (out_result_seconds),
    .out_result_fraction (out_result_fraction),
    .out_order           (out_order)
  );

  timestamp_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_a_seconds        (in_a_seconds),
    .in_a_fraction       (in_a_fraction),
    .in_b_seconds        (in_b_seconds),
    .in_b_fraction       (in_b_fraction),
    .in_factor           (in_factor),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_seconds  (out_result_seconds),
    .out_result_fraction (out_result_fraction),
    .out_order           (out_order),
    .errors              (errors),
    .pending             (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_request(input tau_mode_t mode, input logic [31:0] a_sec,
                              input logic [29:0] a_frac, input logic [31:0] b_sec,
                              input logic [29:0] b_frac, input logic [31:0] fac);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_a_seconds  <= a_sec;
    in_a_fraction <= a_frac;
    in_b_seconds  <= b_sec;
    in_b_fraction <= b_frac;
    in_factor     <= fac;
    do @(posedge clk); while (in_stall);
    // A requested hold-off starts right after this request goes in.
    if (hold_wanted) begin
      hold_reqs++;
      hold_wanted = 1'b0;
    end
    @(negedge clk);
  endtask

  // Returns at a rising edge once every outstanding result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_resolution(input logic use_ns);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= use_ns;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] rand_seconds();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom_range(40) - 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [29:0] rand_fraction(input logic use_ns);
    int unsigned u;
    u = use_ns ? NSEC_PER_SEC : USEC_PER_SEC;
    case ($urandom_range(9))
      0: return '0;
      1: return 30'(u - 1);
      2: return 30'($urandom_range(32'h3FFF_FFFF, u));
      3: return 30'($urandom);
      default: return 30'($urandom_range(u - 1, 0));
    endcase
  endfunction

  function automatic logic [31:0] rand_factor();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'h0001_0000;
      2: return 32'hFFFF_FFFF;
      3, 4: return $urandom_range(32'h0003_FFFF, 0);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input logic use_ns);
    tau_mode_t   mode;
    logic [31:0] a_sec;
    logic [29:0] a_frac;
    logic [31:0] b_sec;
    logic [29:0] b_frac;
    mode   = tau_mode_t'($urandom_range(3));
    a_sec  = rand_seconds();
    a_frac = rand_fraction(use_ns);
    b_sec  = rand_seconds();
    b_frac = rand_fraction(use_ns);
    // Compare needs many ties on the seconds to reach the fraction tests.
    if ($urandom_range(2) == 0) begin
      b_sec = a_sec;
      if ($urandom_range(2) == 0) begin
        b_frac = a_frac;
      end
    end
    send_request(mode, a_sec, a_frac, b_sec, b_frac, rand_factor());
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input logic use_ns,
                           input int count, input int pause_at, input int hold_at);
    wait_results_drained();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_resolution(use_ns);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        hold_wanted = 1'b1;
      end
      if (i == pause_at) begin
        wait_results_drained();
        @(negedge clk);
      end
      send_random(use_ns);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Microsecond resolution straight out of reset.
    send_request(MODE_ADD, 32'd5, 30'd999999, 32'd3, 30'd1, 32'd0);
    send_request(MODE_ADD, 32'h7FFF_FFFF, 30'd0, 32'd1, 30'd0, 32'd0);
    send_request(MODE_ADD, 32'd1, 30'h3FFF_FFFF, 32'd2, 30'd999999, 32'hFFFF_FFFF);
    send_request(MODE_SUB, 32'd10, 30'd1, 32'd3, 30'd500000, 32'd0);
    send_request(MODE_SUB, 32'h8000_0000, 30'd0, 32'd1, 30'd0, 32'd0);
    send_request(MODE_SUB, 32'hFFFF_FFF0, 30'd777, 32'hFFFF_FFF0, 30'd777, 32'd0);
    send_request(MODE_SUB, 32'd0, 30'd0, 32'd0, 30'h3FFF_FFFF, 32'd0);
    send_request(MODE_MUL, 32'd3, 30'd500000, 32'd0, 30'd0, 32'h0001_8000);
    send_request(MODE_MUL, 32'hFFFF_FFFD, 30'd250000, 32'd0, 30'd0, 32'h0001_0000);
    send_request(MODE_MUL, 32'h8000_0000, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 30'd0, 32'hFFFF_FFFF);
    send_request(MODE_MUL, 32'd12345, 30'd54321, 32'd0, 30'd0, 32'd0);
    send_request(MODE_MUL, 32'h7FFF_FFFF, 30'd999999, 32'd0, 30'd0, 32'hFFFF_FFFF);
    send_request(MODE_MUL, 32'hFFFF_FFFF, 30'd0, 32'd0, 30'd0, 32'd1);
    send_request(MODE_MUL, 32'hFFFF_FFFF, 30'd999999, 32'd0, 30'd0, 32'h0000_8001);
    send_request(MODE_CMP, 32'd2, 30'd0, 32'd1, 30'd999999, 32'd0);
    send_request(MODE_CMP, 32'hFFFF_FFFF, 30'd5, 32'd1, 30'd5, 32'd0);
    send_request(MODE_CMP, 32'd7, 30'd123, 32'd7, 30'd123, 32'd0);
    send_request(MODE_CMP, 32'd7, 30'd124, 32'd7, 30'd123, 32'd0);
    send_request(MODE_CMP, 32'd7, 30'd122, 32'd7, 30'd123, 32'd0);
    send_request(MODE_CMP, 32'd0, 30'h3FFF_FFFF, 32'd0, 30'd999999, 32'd0);
    send_request(MODE_CMP, 32'h8000_0000, 30'd0, 32'h7FFF_FFFF, 30'd0, 32'd0);

    run_phase(23, 80, 1'b1, 145, -1, -1);
    run_phase(80, 23, 1'b0, 145, 70, -1);
    run_phase(0, 0, 1'b1, 145, -1, 40);

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

[timestamp_arithmetic_unit_core.f]
hw/rtl/tau_pkg.sv
hw/rtl/tau_front.sv
hw/rtl/tau_scale.sv
hw/rtl/tau_norm.sv
hw/rtl/timestamp_arithmetic_unit_core.sv
hw/rtl/tau_checker.sv
sim/timestamp_checker.sv
sim/tb_top.sv
